// ===== rtl/cte_pkg.sv =====
// shared types, register codes and month tables for the epoch seconds converter
`timescale 1ns / 1ps
`default_nettype none

package cte_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 11;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_UTC_MODE  = 2'd0,
      CSR_ZONE_WEST = 2'd1,
      CSR_DST       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [6:0] year_two_digit;
      logic [6:0] month_number;
      logic [6:0] day_of_month;
      logic [6:0] hour_value;
      logic [6:0] minute_value;
      logic [6:0] second_value;
   } req_type;

   typedef struct packed {
      logic signed [32:0] epoch_seconds;
      logic               bad_date;
   } rsp_type;

   typedef struct packed {
      logic               utc_mode;
      logic signed [10:0] zone_minutes_west;
      logic               dst_active;
   } cfg_type;

   // month length with a 29-day february, zero for codes that are no month
   function automatic logic [4:0] month_days(input logic [3:0] month);
      logic [4:0] len;
      unique case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = 5'd29;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // days before the first of the month, february counted as 29
   function automatic logic [8:0] month_start(input logic [3:0] month);
      logic [8:0] days;
      unique case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd60;
         4'd4:    days = 9'd91;
         4'd5:    days = 9'd121;
         4'd6:    days = 9'd152;
         4'd7:    days = 9'd182;
         4'd8:    days = 9'd213;
         4'd9:    days = 9'd244;
         4'd10:   days = 9'd274;
         4'd11:   days = 9'd305;
         4'd12:   days = 9'd335;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cte_csr.sv =====
// configuration registers: utc mode, zone offset and daylight flag
`timescale 1ns / 1ps
`default_nettype none

module cte_csr
   import cte_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_UTC_MODE:  cfg_in.utc_mode          = csr_data[0];
            CSR_ZONE_WEST: cfg_in.zone_minutes_west = $signed(csr_data);
            CSR_DST:       cfg_in.dst_active        = csr_data[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

`ifndef SYNTHESIS
   a_unknown_index_ignored: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index > CSR_DST) |=> $stable(cfg_ff))
      else $error("write to unused register index changed configuration");

   a_no_write_no_change: assert property (@(posedge clock) disable iff (reset)
      !csr_valid |=> $stable(cfg_ff))
      else $error("configuration changed without a write beat");

   a_zone_write_lands: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == CSR_ZONE_WEST)
         |=> cfg_ff.zone_minutes_west == $signed($past(csr_data)))
      else $error("zone offset write lost");
`endif

endmodule

`default_nettype wire

// ===== rtl/cte_core.sv =====
// input register, date check and seconds arithmetic, result register
`timescale 1ns / 1ps
`default_nettype none

module cte_core
   import cte_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  req_type      in_data,
   input  cfg_type      cfg,
   output logic         out_valid,
   output rsp_type      out_data
);

   logic    stage_valid_ff;
   req_type stage_ff;
   logic    out_valid_ff;
   rsp_type out_ff;
   rsp_type out_in;

   logic               leap;
   logic [6:0]         hour_fix;
   logic [3:0]         month;
   logic [4:0]         month_len;
   logic               bad;
   logic [6:0]         years;
   logic [15:0]        days;
   logic [32:0]        day_sec;
   logic [10:0]        hour_min;
   logic signed [12:0] adjust;
   logic signed [13:0] local_min;
   logic signed [19:0] local_sec;
   logic signed [33:0] total;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= in_valid;
         out_valid_ff   <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         stage_ff <= in_data;
      end
      if (stage_valid_ff) begin
         out_ff <= out_in;
      end
   end

   always_comb begin
      leap      = (stage_ff.year_two_digit[1:0] == 2'b00);
      hour_fix  = (stage_ff.hour_value == 7'd24) ? 7'd0 : stage_ff.hour_value;
      month     = stage_ff.month_number[3:0];
      month_len = month_days(month);

      bad = 1'b0;
      if (stage_ff.month_number < 7'd1 || stage_ff.month_number > 7'd12) begin
         bad = 1'b1;
      end else if (stage_ff.day_of_month < 7'd1 ||
                   stage_ff.day_of_month > {2'b00, month_len}) begin
         bad = 1'b1;
      end else if (stage_ff.day_of_month == 7'd29 && month == 4'd2 && !leap) begin
         bad = 1'b1;
      end
      if (hour_fix > 7'd23 || stage_ff.minute_value > 7'd59 ||
          stage_ff.second_value > 7'd59) begin
         bad = 1'b1;
      end

      // years since 1970; leap days before this year come out as (years + 1) / 4
      years = (stage_ff.year_two_digit < 7'd70) ? stage_ff.year_two_digit + 7'd30
                                                : stage_ff.year_two_digit - 7'd70;
      days = 16'(years) * 16'd365 + 16'((years + 7'd1) >> 2)
           + 16'(month_start(month)) + 16'(stage_ff.day_of_month) - 16'd1;
      if (!leap && month > 4'd2) begin
         days = days - 16'd1;
      end
      day_sec = 33'(days) * 33'd86400;

      hour_min = 11'(hour_fix[4:0]) * 11'd60 + 11'(stage_ff.minute_value[5:0]);
      if (cfg.utc_mode) begin
         adjust = 13'sd0;
      end else begin
         adjust = 13'(cfg.zone_minutes_west) - (cfg.dst_active ? 13'sd60 : 13'sd0);
      end
      local_min = $signed({3'b000, hour_min}) + 14'(adjust);
      local_sec = 20'(local_min) * 20'sd60 + $signed({14'd0, stage_ff.second_value[5:0]});
      total     = $signed({1'b0, day_sec}) + 34'(local_sec);

      out_in.bad_date      = bad;
      out_in.epoch_seconds = bad ? 33'sd0 : $signed(total[32:0]);
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

`ifndef SYNTHESIS
   a_stage_to_result: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff |=> out_valid_ff)
      else $error("accepted beat did not reach the result register");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $past(stage_valid_ff))
      else $error("result strobe without a beat in the input register");

   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.bad_date) |-> out_ff.epoch_seconds == 33'sd0)
      else $error("rejected date carries nonzero seconds");

   a_utc_nonnegative: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && cfg.utc_mode) |-> !out_ff.epoch_seconds[32])
      else $error("negative seconds in utc mode");
`endif

endmodule

`default_nettype wire

// ===== rtl/calendar_to_epoch_seconds.sv =====
// top level of the calendar date to epoch seconds converter
//
// usage:
//   req channel: drive req_data and raise start; a beat is taken at every
//   rising edge with start high and busy low. busy is always low, so a new
//   beat may be offered in every cycle.
//   rsp channel: rsp_strobe is high for one cycle with rsp_data holding
//   epoch_seconds and bad_date. the receiver cannot stall; results appear
//   in the order the beats were taken, one result per beat.
//   path: a taken beat is held in the input register, then its result is
//   registered in the result register and driven on the ports (one input
//   register, one result register).
//   throughput: one beat per cycle, set by the single combinational pass
//   from input register to result register.
//   csr channel: csr_ready is always high; index 0 utc mode, 1 zone offset
//   in minutes west, 2 daylight flag. index 3 is ignored. write only while
//   no beat is in flight.
//   reset: synchronous; clears the pipeline valids and all three registers.
`timescale 1ns / 1ps
`default_nettype none

module calendar_to_epoch_seconds
   import cte_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  req_type                       req_data,
   output logic                          rsp_strobe,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data
);

   cfg_type cfg;

   assign busy = 1'b0;

   cte_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cte_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the calendar date to epoch seconds converter
`timescale 1ns / 1ps

module testbench;
   import cte_pkg::*;

   localparam int EpochYear   = 1970;
   localparam int CenturyBase = 1900;
   localparam int CycleLimit  = 400000;
   localparam int PrintLimit  = 60;
   localparam logic [CsrIndexWidth-1:0] CsrUnused = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   req_type                  req_data = '0;
   logic                     rsp_strobe;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   calendar_to_epoch_seconds uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // bench copy of the registers and the month table
   cfg_type model_cfg = '0;
   int      month_length [12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   req_type pending_dates [$];
   rsp_type expected_stamps [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      gap_left = 0;
   bit      burst_phase = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic rsp_type predict_epoch(req_type d);
      int      yy, mon, day, hour, minute, second, year, m;
      longint  days, t;
      bit      leap, bad;
      rsp_type r;
      yy = d.year_two_digit;
      mon = d.month_number;
      day = d.day_of_month;
      hour = d.hour_value;
      minute = d.minute_value;
      second = d.second_value;
      leap = (yy % 4) == 0;
      bad = 1'b0;
      if (hour == 24)
         hour = 0;
      if (mon < 1 || mon > 12)
         bad = 1'b1;
      else if (day < 1 || day > month_length[mon-1])
         bad = 1'b1;
      else if (day == 29 && mon == 2 && !leap)
         bad = 1'b1;
      if (hour > 23 || minute > 59 || second > 59)
         bad = 1'b1;
      if (bad) begin
         r.epoch_seconds = '0;
         r.bad_date = 1'b1;
         return r;
      end
      year = yy + CenturyBase;
      if (year < EpochYear)
         year += 100;
      days = 365 * (year - EpochYear) + (year - 1) / 4 - (EpochYear - 1) / 4;
      // table counts february as 29 days
      if (!leap && mon > 2)
         days -= 1;
      for (m = 1; m < mon; m++)
         days += month_length[m-1];
      days += day - 1;
      t = 24 * days + hour;
      t = 60 * t + minute;
      if (!model_cfg.utc_mode) begin
         t += $signed(model_cfg.zone_minutes_west);
         if (model_cfg.dst_active)
            t -= 60;
      end
      t = 60 * t + second;
      r.epoch_seconds = t[32:0];
      r.bad_date = 1'b0;
      return r;
   endfunction

   function automatic req_type make_date(int y, int mo, int d, int h, int mi, int s);
      req_type r;
      r.year_two_digit = y[6:0];
      r.month_number = mo[6:0];
      r.day_of_month = d[6:0];
      r.hour_value = h[6:0];
      r.minute_value = mi[6:0];
      r.second_value = s[6:0];
      return r;
   endfunction

   function automatic req_type random_date();
      req_type r;
      int      mon, pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         // raw noise over the whole field range
         r = make_date($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
         return r;
      end
      mon = $urandom_range(1, 12);
      r = make_date(($urandom_range(0, 9) == 0) ? $urandom_range(100, 127) : $urandom_range(0, 99),
                    mon, $urandom_range(1, month_length[mon-1]), $urandom_range(0, 24),
                    $urandom_range(0, 59), $urandom_range(0, 59));
      if (pick < 30) begin
         // break one field of an otherwise sane date
         case ($urandom_range(0, 5))
            0: r.year_two_digit = 7'($urandom_range(0, 127));
            1: r.month_number = 7'($urandom_range(0, 127));
            2: r.day_of_month = 7'($urandom_range(0, 127));
            3: r.hour_value = 7'($urandom_range(0, 127));
            4: r.minute_value = 7'($urandom_range(0, 127));
            default: r.second_value = 7'($urandom_range(0, 127));
         endcase
      end
      return r;
   endfunction

   function automatic int pace_gap();
      int roll;
      if (burst_phase)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < PrintLimit)
         $display("%0t ns: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         CSR_UTC_MODE:  model_cfg.utc_mode = value[0];
         CSR_ZONE_WEST: model_cfg.zone_minutes_west = value;
         CSR_DST:       model_cfg.dst_active = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(bit utc, logic [CsrDataWidth-1:0] zone, bit dst);
      write_csr(CSR_UTC_MODE, {10'($urandom_range(0, 1023)), utc});
      write_csr(CSR_ZONE_WEST, zone);
      write_csr(CSR_DST, {10'($urandom_range(0, 1023)), dst});
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_dates.size() != 0 || start || expected_stamps.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic add_directed();
      pending_dates.push_back(make_date(70, 1, 1, 0, 0, 0));
      pending_dates.push_back(make_date(69, 12, 31, 23, 59, 59));
      pending_dates.push_back(make_date(127, 12, 31, 23, 59, 59));
      pending_dates.push_back(make_date(99, 12, 31, 23, 59, 59));
      pending_dates.push_back(make_date(0, 2, 29, 12, 30, 30));
      pending_dates.push_back(make_date(1, 2, 29, 0, 0, 0));
      pending_dates.push_back(make_date(72, 2, 29, 1, 2, 3));
      pending_dates.push_back(make_date(100, 2, 29, 4, 5, 6));
      pending_dates.push_back(make_date(71, 3, 1, 0, 0, 0));
      pending_dates.push_back(make_date(71, 2, 28, 23, 59, 59));
      pending_dates.push_back(make_date(70, 1, 1, 24, 0, 0));
      pending_dates.push_back(make_date(70, 1, 1, 25, 0, 0));
      pending_dates.push_back(make_date(70, 1, 1, 0, 60, 0));
      pending_dates.push_back(make_date(70, 1, 1, 0, 0, 60));
      pending_dates.push_back(make_date(70, 0, 1, 0, 0, 0));
      pending_dates.push_back(make_date(70, 13, 1, 0, 0, 0));
      pending_dates.push_back(make_date(70, 127, 1, 0, 0, 0));
      pending_dates.push_back(make_date(70, 1, 0, 0, 0, 0));
      pending_dates.push_back(make_date(70, 4, 31, 0, 0, 0));
      pending_dates.push_back(make_date(70, 1, 32, 0, 0, 0));
      pending_dates.push_back(make_date(70, 1, 127, 0, 0, 0));
      pending_dates.push_back(make_date(0, 0, 0, 0, 0, 0));
      pending_dates.push_back(make_date(127, 127, 127, 127, 127, 127));
   endtask

   task automatic run_random(int count);
      burst_phase = ($urandom_range(0, 3) == 0);
      repeat (count) pending_dates.push_back(random_date());
      wait_idle();
   endtask

   // driver: one beat per handshake, random pacing between beats
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            expected_stamps.push_back(predict_epoch(req_data));
         if (start && busy) begin
            // hold the beat until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_dates.size() != 0) begin
            req_data <= pending_dates.pop_front();
            start <= 1'b1;
            gap_left = pace_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results come back in order, one per beat
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_stamps.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_stamps.pop_front();
            if (rsp_data.epoch_seconds !== want.epoch_seconds)
               report_mismatch($sformatf("epoch_seconds got %0d want %0d",
                                         rsp_data.epoch_seconds, want.epoch_seconds));
            if (rsp_data.bad_date !== want.bad_date)
               report_mismatch($sformatf("bad_date got %b want %b",
                                         rsp_data.bad_date, want.bad_date));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: local mode, zone zero, no daylight
      add_directed();
      wait_idle();

      set_config(1'b1, 11'd0, 1'b0);
      add_directed();
      wait_idle();
      run_random(120);

      // most negative directed result lives here
      set_config(1'b0, -11'sd720, 1'b1);
      add_directed();
      wait_idle();
      run_random(150);

      set_config(1'b0, 11'sd720, 1'b0);
      run_random(150);

      // zone beyond the nominal range, plus a write to the unused index
      set_config(1'b0, 11'h400, 1'b1);
      write_csr(CsrUnused, 11'($urandom_range(0, 2047)));
      run_random(150);

      set_config(1'b0, 11'h3FF, 1'b0);
      write_csr(CsrUnused, 11'($urandom_range(0, 2047)));
      run_random(150);

      repeat (8) begin
         if ($urandom_range(0, 1))
            set_config(1'($urandom_range(0, 1)), 11'($urandom_range(0, 1440) - 720),
                       1'($urandom_range(0, 1)));
         else
            set_config(1'($urandom_range(0, 1)), 11'($urandom_range(0, 2047)),
                       1'($urandom_range(0, 1)));
         run_random(130);
      end

      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
